// ----- rtl/ctq_pkg.sv -----
// Shared types, constants and key table for the Cyrillic-to-QWERTY transcoder.
`default_nettype none
package ctq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_OUT     = 3;

    localparam logic [7:0] C_ASCII_LIMIT = 8'h80;
    localparam logic [7:0] C_LEAD_MIN    = 8'hC2;
    localparam logic [7:0] C_LEAD_MASK   = 8'hE0;
    localparam logic [7:0] C_LEAD_TAG    = 8'hC0;
    localparam logic [7:0] C_CONT_MASK   = 8'hC0;
    localparam logic [7:0] C_CONT_TAG    = 8'h80;
    localparam logic [7:0] C_NUM_FIRST   = 8'hE2;
    localparam logic [7:0] C_NUM_SECOND  = 8'h84;
    localparam logic [7:0] C_NUM_THIRD   = 8'h96;
    localparam logic [7:0] C_HASH        = 8'h23;
    localparam logic [10:0] C_CP_GHE_UP  = 11'h490;
    localparam logic [10:0] C_CP_GHE_LO  = 11'h491;
    localparam logic [7:0] C_KEY_GHE_UP  = 8'h55;
    localparam logic [7:0] C_KEY_GHE_LO  = 8'h75;

    localparam int KEY_ROM_SIZE = 96;

    // Key characters for code points 0x0400..0x045F, zero where no key applies.
    localparam logic [7:0] KEY_ROM [KEY_ROM_SIZE] = '{
        8'h00, 8'h7E, 8'h00, 8'h00, 8'h22, 8'h00, 8'h53, 8'h7D,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'h00,
        8'h46, 8'h3C, 8'h44, 8'h55, 8'h4C, 8'h54, 8'h3A, 8'h50,
        8'h42, 8'h51, 8'h52, 8'h4B, 8'h56, 8'h59, 8'h4A, 8'h47,
        8'h48, 8'h43, 8'h4E, 8'h45, 8'h41, 8'h7B, 8'h57, 8'h58,
        8'h49, 8'h4F, 8'h7D, 8'h53, 8'h4D, 8'h22, 8'h3E, 8'h5A,
        8'h66, 8'h2C, 8'h64, 8'h75, 8'h6C, 8'h74, 8'h3B, 8'h70,
        8'h62, 8'h71, 8'h72, 8'h6B, 8'h76, 8'h79, 8'h6A, 8'h67,
        8'h68, 8'h63, 8'h6E, 8'h65, 8'h61, 8'h5B, 8'h77, 8'h78,
        8'h69, 8'h6F, 8'h5D, 8'h73, 8'h6D, 8'h27, 8'h2E, 8'h7A,
        8'h00, 8'h60, 8'h00, 8'h00, 8'h27, 8'h00, 8'h73, 8'h5D,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h75, 8'h00
    };

    // Output words produced by one input word.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
        logic                    conv;
    } t_bundle;

    function automatic t_bundle push_byte(t_bundle bd, logic [7:0] b);
        t_bundle r;
        r = bd;
        if (bd.cnt < 2'(MAX_OUT)) begin
            r.bytes[bd.cnt] = b;
            r.cnt           = bd.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] key_lookup(logic [10:0] cp);
        logic [7:0] k;
        k = 8'h00;
        if (cp[10:7] == 4'b1000 && cp[6:5] != 2'b11) begin
            k = KEY_ROM[cp[6:0]];
        end else if (cp == C_CP_GHE_UP) begin
            k = C_KEY_GHE_UP;
        end else if (cp == C_CP_GHE_LO) begin
            k = C_KEY_GHE_LO;
        end
        return k;
    endfunction

    function automatic logic is_lead(logic [7:0] b);
        return (b >= C_LEAD_MIN && (b & C_LEAD_MASK) == C_LEAD_TAG) || b == C_NUM_FIRST;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cyrillic_to_qwerty_transcoder_core.sv -----
// Path: an accepted input word is written as a bundle into the bundle queue, and
// the output stage then loads that bundle and presents its first output word.
// Throughput: one input word per cycle while the queue has room; one output word
// per cycle while the receiver is ready and the queue holds bundles. An input
// word yields 0 to 3 output words; bursts are absorbed by a bundle queue of
// QUEUE_DEPTH entries, so input stalls only when output lags. Reset (synchronous,
// active low) clears held bytes, converted flag, queue and output stage.
`default_nettype none
module cyrillic_to_qwerty_transcoder_core #(
    parameter int QUEUE_DEPTH = ctq_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic             o_any_converted
);
    import ctq_pkg::*;

    t_bundle f_bundle;
    t_bundle q_data;
    logic    f_push;
    logic    q_full;
    logic    q_empty;
    logic    b_pop;

    ctq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (q_full),
        .o_push    (f_push),
        .o_bundle  (f_bundle)
    );

    ctq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_bundle),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    ctq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_data          (q_data),
        .o_pop           (b_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_any_converted (o_any_converted)
    );

endmodule
`default_nettype wire

// ----- rtl/ctq_front.sv -----
// Front end: holds partial UTF-8 sequences and turns each input word into a bundle.
`default_nettype none
module ctq_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_last,
    input  wire logic            i_full,
    output logic                 o_push,
    output ctq_pkg::t_bundle     o_bundle
);
    import ctq_pkg::*;

    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic [1:0] r_cnt, n_cnt;
    logic       r_conv, n_conv;
    t_bundle    bd;
    logic       do_fresh;
    logic [7:0] key;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign key     = key_lookup({r_first[4:0], i_in_byte[5:0]});

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_cnt    = r_cnt;
        n_conv   = r_conv;
        bd       = '0;
        do_fresh = 1'b0;
        case (r_cnt)
            2'd0: begin
                do_fresh = 1'b1;
            end
            2'd1: begin
                if (r_first != C_NUM_FIRST) begin
                    n_cnt = 2'd0;
                    if ((i_in_byte & C_CONT_MASK) == C_CONT_TAG) begin
                        if (key != 8'h00) begin
                            bd     = push_byte(bd, key);
                            n_conv = 1'b1;
                        end else begin
                            bd = push_byte(bd, r_first);
                            bd = push_byte(bd, i_in_byte);
                        end
                    end else begin
                        bd       = push_byte(bd, r_first);
                        do_fresh = 1'b1;
                    end
                end else if (i_in_byte == C_NUM_SECOND) begin
                    n_second = i_in_byte;
                    n_cnt    = 2'd2;
                end else begin
                    n_cnt    = 2'd0;
                    bd       = push_byte(bd, r_first);
                    do_fresh = 1'b1;
                end
            end
            default: begin
                n_cnt = 2'd0;
                if (i_in_byte == C_NUM_THIRD) begin
                    bd     = push_byte(bd, C_HASH);
                    n_conv = 1'b1;
                end else begin
                    bd       = push_byte(bd, r_first);
                    bd       = push_byte(bd, r_second);
                    do_fresh = 1'b1;
                end
            end
        endcase
        if (do_fresh) begin
            if (i_in_byte >= C_ASCII_LIMIT && is_lead(i_in_byte)) begin
                n_first = i_in_byte;
                n_cnt   = 2'd1;
            end else begin
                bd = push_byte(bd, i_in_byte);
            end
        end
        // end of string: flush whatever is held
        if (i_in_last) begin
            if (n_cnt >= 2'd1) begin
                bd = push_byte(bd, n_first);
            end
            if (n_cnt >= 2'd2) begin
                bd = push_byte(bd, n_second);
            end
            n_cnt = 2'd0;
        end
        bd.last = i_in_last;
        bd.conv = n_conv;
        if (i_in_last) begin
            n_conv = 1'b0;
        end
    end

    assign o_push   = accept && bd.cnt != 2'd0;
    assign o_bundle = bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_cnt    <= '0;
            r_conv   <= 1'b0;
        end else if (accept) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_cnt    <= n_cnt;
            r_conv   <= n_conv;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ctq_fifo.sv -----
// Bundle queue between front and back ends.
`default_nettype none
module ctq_fifo #(
    parameter int DEPTH = ctq_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ctq_pkg::t_bundle i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output ctq_pkg::t_bundle      o_data
);
    import ctq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ctq_back.sv -----
// Back end: unpacks bundles into single output words from a registered stage.
`default_nettype none
module ctq_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire ctq_pkg::t_bundle i_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    output logic                  o_any_converted
);
    import ctq_pkg::*;

    t_bundle    r_cur;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       at_end;
    logic       load;

    assign at_end = r_idx == (r_cur.cnt - 2'd1);
    assign load   = !r_valid || (i_ready && at_end);
    assign o_pop  = load && !i_empty;

    assign o_valid         = r_valid;
    assign o_out_byte      = r_cur.bytes[r_idx];
    assign o_out_last      = r_cur.last && at_end;
    assign o_any_converted = r_cur.last && at_end && r_cur.conv;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_idx   <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- verif/cyrillic_to_qwerty_transcoder_checker.sv -----
// Channel monitor, transcoding predictor and output comparison for the transcoder core.
`timescale 1ns / 100ps
module cyrillic_to_qwerty_transcoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    input  logic       i_out_any_converted,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_words_checked,
    output int         o_converted_strings
);

    localparam logic [7:0] NUMERO_LEAD = 8'hE2;
    localparam logic [7:0] NUMERO_MID  = 8'h84;
    localparam logic [7:0] NUMERO_END  = 8'h96;
    localparam logic [7:0] HASH_CHAR   = 8'h23;
    localparam logic [7:0] NO_KEY      = 8'h40;  // '@' never appears as a key
    localparam int         WORDS_MAX   = 3;
    localparam int         REPORT_MAX  = 10;

    // Key characters for U+0400..U+045F, sixteen code points per string, '@' = unmapped.
    localparam logic [96*8-1:0] KEY_CHARS = {
        "@~@@\"@S}@@@@@@U@",
        "F<DULT:PBQRKVYJG",
        "HCNEA{WXIO}SM\">Z",
        "f,dult;pbqrkvyjg",
        "hcnea[wxio]sm'.z",
        "@`@@'@s]@@@@@@u@"
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       conv;
    } t_out_word;

    t_out_word  expected_words[$];
    logic [7:0] step_bytes[$];
    logic [7:0] lead_byte;
    logic [7:0] mid_byte;
    logic [1:0] held_n;
    logic       conv_flag;

    function automatic logic [7:0] qwerty_key(input logic [10:0] cp);
        int         idx;
        logic [7:0] k;
        k = 8'h00;
        if (cp >= 11'h400 && cp < 11'h460) begin
            idx = 32'h45F - int'(cp);
            k   = KEY_CHARS[idx*8 +: 8];
            if (k == NO_KEY) begin
                k = 8'h00;
            end
        end else if (cp == 11'h490) begin
            k = "U";
        end else if (cp == 11'h491) begin
            k = "u";
        end
        return k;
    endfunction

    task put_byte(input logic [7:0] b);
        if (step_bytes.size() < WORDS_MAX) begin
            step_bytes.insert(step_bytes.size(), b);
        end
    endtask

    task start_fresh(input logic [7:0] b);
        if (b < 8'h80) begin
            put_byte(b);
        end else if ((b >= 8'hC2 && b[7:5] == 3'b110) || b == NUMERO_LEAD) begin
            lead_byte = b;
            held_n    = 2'd1;
        end else begin
            put_byte(b);
        end
    endtask

    task absorb_byte(input logic [7:0] b);
        logic [10:0] cp;
        logic [7:0]  k;
        if (held_n == 2'd0) begin
            start_fresh(b);
        end else if (held_n == 2'd1) begin
            held_n = 2'd0;
            if (lead_byte != NUMERO_LEAD) begin
                if (b[7:6] == 2'b10) begin
                    cp = {lead_byte[4:0], b[5:0]};
                    k  = qwerty_key(cp);
                    if (k != 8'h00) begin
                        put_byte(k);
                        conv_flag = 1'b1;
                    end else begin
                        put_byte(lead_byte);
                        put_byte(b);
                    end
                end else begin
                    put_byte(lead_byte);
                    start_fresh(b);
                end
            end else if (b == NUMERO_MID) begin
                mid_byte = b;
                held_n   = 2'd2;
            end else begin
                put_byte(lead_byte);
                start_fresh(b);
            end
        end else begin
            // two held bytes: only the numero sign prefix gets here
            held_n = 2'd0;
            if (b == NUMERO_END) begin
                put_byte(HASH_CHAR);
                conv_flag = 1'b1;
            end else begin
                put_byte(lead_byte);
                put_byte(mid_byte);
                start_fresh(b);
            end
        end
    endtask

    task transcode_byte(input logic [7:0] b, input logic last);
        t_out_word w;
        int        n;
        step_bytes.delete();
        absorb_byte(b);
        if (last) begin
            if (held_n >= 2'd1) begin
                put_byte(lead_byte);
            end
            if (held_n >= 2'd2) begin
                put_byte(mid_byte);
            end
            held_n = 2'd0;
        end
        n = step_bytes.size();
        for (int k = 0; k < n; k++) begin
            w.ch   = step_bytes[k];
            w.fin  = last && (k == n - 1);
            w.conv = w.fin ? conv_flag : 1'b0;
            expected_words.insert(expected_words.size(), w);
        end
        if (last) begin
            conv_flag = 1'b0;
        end
    endtask

    task check_word();
        t_out_word want;
        if (expected_words.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_MAX) begin
                $display("%0t: word %0d arrived with nothing expected: byte %h last %b conv %b",
                         $realtime, o_words_checked, i_out_byte, i_out_last,
                         i_out_any_converted);
            end
        end else begin
            want = expected_words.pop_front();
            if (want.ch !== i_out_byte || want.fin !== i_out_last
                    || want.conv !== i_out_any_converted) begin
                o_mismatches++;
                if (o_mismatches <= REPORT_MAX) begin
                    $display("%0t: word %0d: expected byte %h last %b conv %b, got byte %h last %b conv %b",
                             $realtime, o_words_checked, want.ch, want.fin, want.conv,
                             i_out_byte, i_out_last, i_out_any_converted);
                end
            end
        end
        if (i_out_last && i_out_any_converted) begin
            o_converted_strings++;
        end
        o_words_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            lead_byte           = 8'h00;
            mid_byte            = 8'h00;
            held_n              = 2'd0;
            conv_flag           = 1'b0;
            o_mismatches        = 0;
            o_words_checked     = 0;
            o_converted_strings = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                transcode_byte(i_in_byte, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_word();
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ----- verif/cyrillic_to_qwerty_transcoder_core_test.sv -----
// Stimulus, flow control and verdict for the Cyrillic-to-QWERTY transcoder core.
`timescale 1ns / 100ps
module cyrillic_to_qwerty_transcoder_core_test;

    localparam logic [7:0] NUMERO_LEAD  = 8'hE2;
    localparam logic [7:0] NUMERO_MID   = 8'h84;
    localparam logic [7:0] NUMERO_END   = 8'h96;
    localparam int         IDLE_PCT     = 29;
    localparam int         RANDOM_WORDS = 340;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         SETTLE_CYCLES = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_any_converted;

    int mismatches;
    int pending;
    int words_checked;
    int converted_strings;

    int         tx_idle_pct;
    int         rx_idle_pct;
    bit         hold_req;
    bit         random_phase;
    int         words_sent;
    int         strings_sent;
    int         random_words;
    logic [7:0] string_bytes[$];

    cyrillic_to_qwerty_transcoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_any_converted (o_any_converted)
    );

    cyrillic_to_qwerty_transcoder_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_in_byte           (i_in_byte),
        .i_in_last           (i_in_last),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_out_byte          (o_out_byte),
        .i_out_last          (o_out_last),
        .i_out_any_converted (o_any_converted),
        .o_mismatches        (mismatches),
        .o_pending           (pending),
        .o_words_checked     (words_checked),
        .o_converted_strings (converted_strings)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d words still expected", pending);
        $display("** cyrillic_to_qwerty_transcoder_core: FAILED **");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        string_bytes.insert(string_bytes.size(), b);
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic send_string_bytes();
        int n;
        n = string_bytes.size();
        for (int k = 0; k < n; k++) begin
            send_word(string_bytes[k], k == n - 1);
            if (random_phase) begin
                random_words++;
                if (random_words == 100) begin
                    hold_req = 1'b1;
                end
                // quiet stretch: neither side idles
                tx_idle_pct = (random_words >= 180 && random_words < 260) ? 0 : IDLE_PCT;
                rx_idle_pct = tx_idle_pct;
            end
        end
        string_bytes.delete();
        strings_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Mostly Cyrillic text, some numero signs and ASCII, the rest broken sequences and noise.
    task automatic build_random_string();
        int          n_chars;
        int          kind;
        logic [10:0] cp;
        n_chars = $urandom_range(1, 10);
        repeat (n_chars) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                if (kind < 40) begin
                    cp = 11'h400 + 11'($urandom_range(95));
                end else if (kind < 44) begin
                    cp = 11'h490 + 11'($urandom_range(1));
                end else begin
                    cp = 11'($urandom_range(11'h7FF, 11'h080));
                end
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end else if (kind < 58) begin
                add_byte(NUMERO_LEAD);
                add_byte(NUMERO_MID);
                add_byte(NUMERO_END);
            end else if (kind < 80) begin
                add_byte(8'($urandom_range(8'h7F)));
            end else if (kind < 86) begin
                add_byte(8'($urandom_range(8'hFF)));
            end else if (kind < 90) begin
                add_byte(8'hC2 + 8'($urandom_range(29)));
                add_byte(8'($urandom_range(8'h7F)));
            end else if (kind < 94) begin
                add_byte(NUMERO_LEAD);
                add_byte(8'($urandom_range(8'hFF)));
            end else if (kind < 97) begin
                add_byte(NUMERO_LEAD);
                add_byte(NUMERO_MID);
                add_byte(8'($urandom_range(8'hFF)));
            end else begin
                add_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_in_byte    = 8'h00;
        i_in_last    = 1'b0;
        i_ready      = 1'b0;
        hold_req     = 1'b0;
        random_phase = 1'b0;
        tx_idle_pct  = IDLE_PCT;
        rx_idle_pct  = IDLE_PCT;
        words_sent   = 0;
        strings_sent = 0;
        random_words = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ASCII extremes, nothing converted
        string_bytes = '{8'h00, 8'h7F};
        send_string_bytes();
        // mapped letters including yo
        string_bytes = '{8'hD0, 8'h90, 8'hD1, 8'h91};
        send_string_bytes();
        // ghe with upturn, unmapped code points, lead without continuation
        string_bytes = '{8'hD2, 8'h90, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hD0, 8'h41};
        send_string_bytes();
        // numero sign, broken numero signs, lone continuation, invalid leads
        string_bytes = '{NUMERO_LEAD, NUMERO_MID, NUMERO_END, NUMERO_LEAD, NUMERO_MID, 8'h41,
                         NUMERO_LEAD, 8'h41, NUMERO_MID, 8'hC0, 8'hFF, 8'hE0};
        send_string_bytes();
        // strings ending on held bytes
        string_bytes = '{8'hD0};
        send_string_bytes();
        string_bytes = '{NUMERO_LEAD, NUMERO_MID};
        send_string_bytes();

        drain();

        random_phase = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            build_random_string();
            send_string_bytes();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d input words in %0d strings, with one long output hold-off.",
                 words_sent, strings_sent);
        $display("Checked %0d output words; %0d strings reported a conversion.",
                 words_checked, converted_strings);
        if (mismatches == 0 && pending == 0) begin
            $display("** cyrillic_to_qwerty_transcoder_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d words never arrived", mismatches, pending);
            $display("** cyrillic_to_qwerty_transcoder_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ctq_pkg.sv
rtl/ctq_front.sv
rtl/ctq_fifo.sv
rtl/ctq_back.sv
rtl/cyrillic_to_qwerty_transcoder_core.sv
verif/cyrillic_to_qwerty_transcoder_checker.sv
verif/cyrillic_to_qwerty_transcoder_core_test.sv
